[rtl/drp_pkg.sv]
// ----------------------------------------------------------------------------
// drp_pkg: shared definitions for the database record parser
// Sizes, serial type codes, result kinds, error codes and helper functions.
// ----------------------------------------------------------------------------
package drp_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int LENGTH_BITS = 32;
	localparam int COL_CAP     = (MAX_COLUMNS < 64) ? MAX_COLUMNS : 64;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 7;
	localparam int TBL_DEPTH   = 64;

	typedef logic [LENGTH_BITS-1:0] stype_t;

	typedef enum logic [3:0] {
		PH_HLEN   = 4'b0001,
		PH_TYPES  = 4'b0010,
		PH_VALUES = 4'b0100,
		PH_DRAIN  = 4'b1000
	} phase_t;

	localparam stype_t TYPE_NULL     = stype_t'(0);
	localparam stype_t TYPE_FLOAT    = stype_t'(7);
	localparam stype_t TYPE_ZERO     = stype_t'(8);
	localparam stype_t TYPE_ONE      = stype_t'(9);
	localparam stype_t TYPE_RSV_A    = stype_t'(10);
	localparam stype_t TYPE_RSV_B    = stype_t'(11);
	localparam stype_t TYPE_BLOB_MIN = stype_t'(12);

	localparam logic [2:0] KIND_NULL       = 3'd0;
	localparam logic [2:0] KIND_INT        = 3'd1;
	localparam logic [2:0] KIND_FLOAT      = 3'd2;
	localparam logic [2:0] KIND_TEXT       = 3'd3;
	localparam logic [2:0] KIND_BLOB       = 3'd4;
	localparam logic [2:0] KIND_EMPTY_TEXT = 3'd5;
	localparam logic [2:0] KIND_EMPTY_BLOB = 3'd6;
	localparam logic [2:0] KIND_ERROR      = 3'd7;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_RESERVED  = 3'd1;
	localparam logic [2:0] ERR_COLUMNS   = 3'd2;
	localparam logic [2:0] ERR_TRUNCATED = 3'd3;
	localparam logic [2:0] ERR_VARINT    = 3'd4;

	// Number of body bytes a serial type occupies.
	function automatic stype_t body_length(input stype_t t);
		stype_t r;
		r = '0;
		if (t >= TYPE_BLOB_MIN) begin
			r = (t - TYPE_BLOB_MIN) >> 1;
		end else begin
			case (t[3:0])
				4'd1: r = stype_t'(1);
				4'd2: r = stype_t'(2);
				4'd3: r = stype_t'(3);
				4'd4: r = stype_t'(4);
				4'd5: r = stype_t'(6);
				4'd6: r = stype_t'(8);
				4'd7: r = stype_t'(8);
				default: r = '0;
			endcase
		end
		return r;
	endfunction

	// Sign extend a big-endian integer body of serial type 1..6.
	function automatic logic [63:0] sign_extend(input logic [63:0] a, input stype_t t);
		logic [63:0] r;
		r = a;
		case (t[3:0])
			4'd1: r = {{56{a[7]}}, a[7:0]};
			4'd2: r = {{48{a[15]}}, a[15:0]};
			4'd3: r = {{40{a[23]}}, a[23:0]};
			4'd4: r = {{32{a[31]}}, a[31:0]};
			4'd5: r = {{16{a[47]}}, a[47:0]};
			default: r = a;
		endcase
		return r;
	endfunction

	// Clamp a column number to the width of the column_index field.
	function automatic logic [IDX_W-1:0] sat_col(input logic [CNT_W-1:0] c);
		return c[CNT_W-1] ? {IDX_W{1'b1}} : c[IDX_W-1:0];
	endfunction

endpackage

[rtl/drp_in_if.sv]
// ----------------------------------------------------------------------------
// drp_in_if: record payload byte channel
// One transaction moves one payload byte and its end-of-record mark.
// ----------------------------------------------------------------------------
interface drp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink   (input valid, in_byte, in_last, output ready);
endinterface

[rtl/drp_out_if.sv]
// ----------------------------------------------------------------------------
// drp_out_if: decoded result channel
// One transaction moves one decoded column value, data byte or error.
// ----------------------------------------------------------------------------
interface drp_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  column_index;
	logic [2:0]  value_kind;
	logic [63:0] value_bits;
	logic [31:0] byte_offset;
	logic        column_end;
	logic        record_end;
	logic [2:0]  error_code;

	modport source (output valid, column_index, value_kind, value_bits, byte_offset,
		column_end, record_end, error_code, input ready);
	modport sink   (input valid, column_index, value_kind, value_bits, byte_offset,
		column_end, record_end, error_code, output ready);
endinterface

[rtl/drp_type_table.sv]
// ----------------------------------------------------------------------------
// drp_type_table: serial type store
// One write port, one registered read port with write-through bypass.
// ----------------------------------------------------------------------------
module drp_type_table
	import drp_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  stype_t           wdata,
	input  logic [IDX_W-1:0] raddr,
	output stype_t           rdata_q
);

	stype_t mem [TBL_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Data written in the same cycle as it is addressed is forwarded.
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

[rtl/database_record_parser.sv]
// ----------------------------------------------------------------------------
// database_record_parser: record format decoder
// Parses a record payload byte stream into typed column results.
// ----------------------------------------------------------------------------
// The parser takes one payload byte per cycle and gives one result
// transaction per cycle while nothing stalls it. Each column of zero body
// length (null, 0, 1, empty text or blob) that falls due after a byte is
// emitted in a step of its own, during which no byte is taken; after the
// final byte of a record (in_last) a further step closes the record and,
// where the record is incomplete, delivers the truncation error. These
// extra steps come from the single result register, which holds one
// result at a time. A byte is taken only in a cycle in which the result
// register is empty or is being drained, so a stalled receiver stalls the
// payload channel as well. The serial types live in a 64-entry table; the
// type of the next column is read ahead so that a column switch needs no
// wait.
// ----------------------------------------------------------------------------
module database_record_parser
	import drp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	drp_in_if.sink    payload,
	drp_out_if.source result
);

	localparam int LW = LENGTH_BITS;

	// Record state.
	phase_t               phase_q, phase_n;
	logic [63:0]          vacc_q, vacc_n;
	logic [3:0]           vbytes_q, vbytes_n;
	stype_t               hlen_q, hlen_n;
	logic [LW:0]          hcons_q, hcons_n;
	logic [CNT_W-1:0]     count_q, count_n;
	logic [CNT_W-1:0]     col_q, col_n;
	stype_t               left_q, left_n;
	logic [63:0]          vaccum_q, vaccum_n;
	logic [31:0]          doff_q, doff_n;
	stype_t               cur_type_q, cur_type_n;
	stype_t               first_type_q, first_type_n;
	logic                 pend_last_q, pend_last_n;

	// Result register.
	logic                 out_valid_q;
	logic [IDX_W-1:0]     o_col_q, o_col_n;
	logic [2:0]           o_kind_q, o_kind_n;
	logic [63:0]          o_bits_q, o_bits_n;
	logic [31:0]          o_off_q, o_off_n;
	logic                 o_cend_q, o_cend_n;
	logic                 o_rend_q, o_rend_n;
	logic [2:0]           o_err_q, o_err_n;
	logic                 emit;

	// Type table.
	logic                 tbl_we;
	logic [IDX_W-1:0]     tbl_raddr;
	stype_t               tbl_rdata;

	logic                 step, cascade_due, take;
	logic [63:0]          acc_feed;
	logic [3:0]           vb_feed;
	logic                 vdone;
	stype_t               v;
	stype_t               t0;
	stype_t               left_dec;
	logic                 rend_cur;

	// The result register can take a new result when it is empty or being
	// drained in this cycle.
	assign step        = !out_valid_q || result.ready;
	assign cascade_due = (phase_q == PH_VALUES) && (left_q == '0);
	assign payload.ready = step && !cascade_due && !pend_last_q;
	assign take        = payload.valid && payload.ready;

	// Varint byte assembly: seven bits per byte for eight bytes, then a full
	// final byte.
	always_comb begin
		if (vbytes_q >= 4'd8) begin
			acc_feed = {vacc_q[55:0], payload.in_byte};
			vb_feed  = vbytes_q;
			vdone    = 1'b1;
		end else begin
			acc_feed = {vacc_q[56:0], payload.in_byte[6:0]};
			vb_feed  = vbytes_q + 4'd1;
			vdone    = !payload.in_byte[7];
		end
	end

	assign v        = acc_feed[LW-1:0];
	assign t0       = (count_q == '0) ? v : first_type_q;
	assign left_dec = left_q - stype_t'(1);
	assign rend_cur = (col_q + CNT_W'(1)) >= count_q;

	always_comb begin
		phase_n      = phase_q;
		vacc_n       = vacc_q;
		vbytes_n     = vbytes_q;
		hlen_n       = hlen_q;
		hcons_n      = hcons_q;
		count_n      = count_q;
		col_n        = col_q;
		left_n       = left_q;
		vaccum_n     = vaccum_q;
		doff_n       = doff_q;
		cur_type_n   = cur_type_q;
		first_type_n = first_type_q;
		pend_last_n  = pend_last_q;
		tbl_we       = 1'b0;
		emit         = 1'b0;
		o_col_n      = sat_col(col_q);
		o_kind_n     = KIND_NULL;
		o_bits_n     = '0;
		o_off_n      = '0;
		o_cend_n     = 1'b1;
		o_rend_n     = 1'b0;
		o_err_n      = ERR_NONE;

		if (step && cascade_due) begin
			// A zero-length column is due: emit it and move to the next one.
			emit     = 1'b1;
			o_rend_n = rend_cur;
			if (cur_type_q == TYPE_NULL) begin
				o_kind_n = KIND_NULL;
			end else if (cur_type_q == TYPE_ZERO) begin
				o_kind_n = KIND_INT;
			end else if (cur_type_q == TYPE_ONE) begin
				o_kind_n = KIND_INT;
				o_bits_n = 64'd1;
			end else if (cur_type_q[0]) begin
				o_kind_n = KIND_EMPTY_TEXT;
			end else begin
				o_kind_n = KIND_EMPTY_BLOB;
			end
			col_n      = col_q + CNT_W'(1);
			phase_n    = (col_n >= count_q) ? PH_DRAIN : PH_VALUES;
			cur_type_n = tbl_rdata;
			left_n     = body_length(tbl_rdata);
			doff_n     = '0;
			vaccum_n   = '0;
		end else if (step && pend_last_q) begin
			// Close the record; an incomplete one reports truncation.
			pend_last_n = 1'b0;
			if (phase_q != PH_DRAIN) begin
				emit     = 1'b1;
				o_kind_n = KIND_ERROR;
				o_rend_n = 1'b1;
				o_err_n  = ERR_TRUNCATED;
				o_col_n  = sat_col((phase_q == PH_VALUES) ? col_q : count_q);
			end
			phase_n  = PH_HLEN;
			vacc_n   = '0;
			vbytes_n = '0;
			hlen_n   = '0;
			hcons_n  = '0;
			count_n  = '0;
			col_n    = '0;
			left_n   = '0;
			vaccum_n = '0;
			doff_n   = '0;
		end else if (take) begin
			pend_last_n = payload.in_last;
			case (phase_q)
				PH_HLEN, PH_TYPES: begin
					hcons_n  = hcons_q + (LW+1)'(1);
					vacc_n   = acc_feed;
					vbytes_n = vb_feed;
					if (vdone) begin
						vacc_n   = '0;
						vbytes_n = '0;
						if (acc_feed[63:LW] != '0) begin
							emit     = 1'b1;
							o_kind_n = KIND_ERROR;
							o_rend_n = 1'b1;
							o_err_n  = ERR_VARINT;
							o_col_n  = sat_col((phase_q == PH_HLEN) ? '0 : count_q);
							phase_n  = PH_DRAIN;
						end else if (phase_q == PH_HLEN) begin
							hlen_n  = v;
							phase_n = PH_TYPES;
							// A header with no room for types holds no columns.
							if (hcons_n >= {1'b0, v}) begin
								col_n   = '0;
								phase_n = PH_DRAIN;
							end
						end else if ((v == TYPE_RSV_A) || (v == TYPE_RSV_B)) begin
							emit     = 1'b1;
							o_kind_n = KIND_ERROR;
							o_rend_n = 1'b1;
							o_err_n  = ERR_RESERVED;
							o_col_n  = sat_col(count_q);
							phase_n  = PH_DRAIN;
						end else if (count_q >= CNT_W'(COL_CAP)) begin
							emit     = 1'b1;
							o_kind_n = KIND_ERROR;
							o_rend_n = 1'b1;
							o_err_n  = ERR_COLUMNS;
							o_col_n  = sat_col(count_q);
							phase_n  = PH_DRAIN;
						end else begin
							tbl_we  = 1'b1;
							count_n = count_q + CNT_W'(1);
							if (count_q == '0) begin
								first_type_n = v;
							end
							if (hcons_n >= {1'b0, hlen_q}) begin
								col_n      = '0;
								phase_n    = PH_VALUES;
								cur_type_n = t0;
								left_n     = body_length(t0);
								doff_n     = '0;
								vaccum_n   = '0;
							end
						end
					end
				end
				PH_VALUES: begin
					left_n   = left_dec;
					o_rend_n = rend_cur;
					if (cur_type_q >= TYPE_BLOB_MIN) begin
						emit     = 1'b1;
						o_kind_n = cur_type_q[0] ? KIND_TEXT : KIND_BLOB;
						o_bits_n = {56'd0, payload.in_byte};
						o_off_n  = doff_q;
						o_cend_n = (left_dec == '0);
						o_rend_n = (left_dec == '0) && rend_cur;
						doff_n   = doff_q + 32'd1;
					end else begin
						vaccum_n = {vaccum_q[55:0], payload.in_byte};
						if (left_dec == '0) begin
							emit = 1'b1;
							if (cur_type_q == TYPE_FLOAT) begin
								o_kind_n = KIND_FLOAT;
								o_bits_n = vaccum_n;
							end else begin
								o_kind_n = KIND_INT;
								o_bits_n = sign_extend(vaccum_n, cur_type_q);
							end
						end
					end
					if (left_dec == '0) begin
						col_n      = col_q + CNT_W'(1);
						phase_n    = (col_n >= count_q) ? PH_DRAIN : PH_VALUES;
						cur_type_n = tbl_rdata;
						left_n     = body_length(tbl_rdata);
						doff_n     = '0;
						vaccum_n   = '0;
					end
				end
				default: begin
					// Trailing bytes are dropped until the end of the record.
				end
			endcase
		end
	end

	// The read port always fetches the column after the one that will be
	// current, so a column switch finds its type already registered.
	assign tbl_raddr = col_n[IDX_W-1:0] + IDX_W'(1);

	drp_type_table u_type_table (
		.clk     (clk),
		.we      (tbl_we),
		.waddr   (count_q[IDX_W-1:0]),
		.wdata   (v),
		.raddr   (tbl_raddr),
		.rdata_q (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HLEN;
			vacc_q      <= '0;
			vbytes_q    <= '0;
			hlen_q      <= '0;
			hcons_q     <= '0;
			count_q     <= '0;
			col_q       <= '0;
			left_q      <= '0;
			vaccum_q    <= '0;
			doff_q      <= '0;
			pend_last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_n;
			vacc_q      <= vacc_n;
			vbytes_q    <= vbytes_n;
			hlen_q      <= hlen_n;
			hcons_q     <= hcons_n;
			count_q     <= count_n;
			col_q       <= col_n;
			left_q      <= left_n;
			vaccum_q    <= vaccum_n;
			doff_q      <= doff_n;
			pend_last_q <= pend_last_n;
			if (step) begin
				out_valid_q <= emit;
			end
		end
	end

	// Type registers and the result payload need no reset.
	always_ff @(posedge clk) begin
		cur_type_q   <= cur_type_n;
		first_type_q <= first_type_n;
		if (step && emit) begin
			o_col_q  <= o_col_n;
			o_kind_q <= o_kind_n;
			o_bits_q <= o_bits_n;
			o_off_q  <= o_off_n;
			o_cend_q <= o_cend_n;
			o_rend_q <= o_rend_n;
			o_err_q  <= o_err_n;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.column_index = o_col_q;
	assign result.value_kind   = o_kind_q;
	assign result.value_bits   = o_bits_q;
	assign result.byte_offset  = o_off_q;
	assign result.column_end   = o_cend_q;
	assign result.record_end   = o_rend_q;
	assign result.error_code   = o_err_q;

endmodule
